[rtl/core/fppp_pkg.sv]
// ----------------------------------------------------------------------------
// fppp_pkg
// Shared constants and types for the perspective point plotter.
// ----------------------------------------------------------------------------
package fppp_pkg;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 200;
   localparam int FRAC_BITS     = 12;
   localparam int PERSP_BITS    = 11;

   localparam int COL_SHIFT = FRAC_BITS + PERSP_BITS - 3;
   localparam int ROW_SHIFT = FRAC_BITS + PERSP_BITS - 5;

   // divider geometry
   localparam int NUM_W = 16 + PERSP_BITS;   // numerator magnitude bits
   localparam int DEN_W = 40;                // divisor magnitude bits
   localparam int QUO_W = NUM_W;

   localparam logic [3:0] REG_SIN_THETA = 4'd0;
   localparam logic [3:0] REG_SIN_PHI   = 4'd1;
   localparam logic [3:0] REG_COS_THETA = 4'd2;
   localparam logic [3:0] REG_COS_PHI   = 4'd3;
   localparam logic [3:0] REG_VIEW_DIST = 4'd4;
   localparam logic [3:0] REG_SCR_DIST  = 4'd5;

   // payload carried along the divider row
   typedef struct packed {
      logic signed [31:0] xe;
      logic signed [31:0] ye;
      logic               neg;
      logic               dv_zero;
      logic [7:0]         colour;
   } side_type;

   // one divider cell's working value
   typedef struct packed {
      logic [NUM_W-1:0] rem_num;  // remaining numerator bits, shifted out msb first
      logic [DEN_W:0]   part;     // partial remainder
      logic [QUO_W-1:0] quo;
      logic [DEN_W-1:0] den;
   } div_type;

endpackage

[rtl/core/fppp_div_cell.sv]
// ----------------------------------------------------------------------------
// fppp_div_cell
// One restoring-division step; registers its result for the next cell.
// ----------------------------------------------------------------------------
module fppp_div_cell
   import fppp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     valid_in,
   input  div_type  div_in,
   input  side_type side_in,
   output logic     valid_out,
   output div_type  div_out,
   output side_type side_out
);

   logic     valid_ff, valid_in_d;
   div_type  div_ff, div_in_d;
   side_type side_ff;
   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;

   assign valid_in_d = valid_in;

   always_comb begin
      trial = {div_in.part[DEN_W-1:0], div_in.rem_num[NUM_W-1]};
      diff  = trial - {1'b0, div_in.den};
      div_in_d         = div_in;
      div_in_d.rem_num = {div_in.rem_num[NUM_W-2:0], 1'b0};
      if (!diff[DEN_W]) begin
         div_in_d.part = diff;
         div_in_d.quo  = {div_in.quo[QUO_W-2:0], 1'b1};
      end else begin
         div_in_d.part = trial;
         div_in_d.quo  = {div_in.quo[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in_d;
      end
      if (advance) begin
         div_ff  <= div_in_d;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign div_out   = div_ff;
   assign side_out  = side_ff;

endmodule

[rtl/core/fixed_point_perspective_plotter_unit.sv]
// ----------------------------------------------------------------------------
// fixed_point_perspective_plotter_unit
// Rotates, projects and clips world points to a framebuffer offset.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one point per transaction, tdata holds x, y, z, colour.
//   rsp_ channel: tdata holds pixel offset and colour; only on-screen points
//   produce a transaction, others vanish inside the pipeline.
//   csr_ port: register writes; write only while the unit is idle, the block itself does not enforce this.
// Throughput: one point per cycle while the output is not stalled.
// Pipeline: stages 1 to 4, then the 27-cell divider row, one quotient
//   bit per cell, then stages A and B and the output register.
// Reset: clears all valid flags and loads register defaults.
// Stall: the whole pipeline advances only when its output slot is free or
//   being taken, so a stalled receiver holds everything in place; req_tready
//   stays high while the output slot can drain.
// ----------------------------------------------------------------------------
module fixed_point_perspective_plotter_unit
   import fppp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // point_x, point_y, point_z, pixel_colour
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // pixel_offset, plot_colour
   input  logic        csr_we,
   input  logic [3:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   logic signed [13:0] sin_t_ff, sin_p_ff, cos_t_ff, cos_p_ff;
   logic signed [23:0] vd_ff;
   logic [15:0]        sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_t_ff <= '0;
         sin_p_ff <= '0;
         cos_t_ff <= 14'sd4096;
         cos_p_ff <= 14'sd4096;
         vd_ff    <= 24'sd1024;
         sd_ff    <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SIN_THETA: sin_t_ff <= csr_wdata[13:0];
            REG_SIN_PHI:   sin_p_ff <= csr_wdata[13:0];
            REG_COS_THETA: cos_t_ff <= csr_wdata[13:0];
            REG_COS_PHI:   cos_p_ff <= csr_wdata[13:0];
            REG_VIEW_DIST: vd_ff    <= csr_wdata;
            REG_SCR_DIST:  sd_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic out_valid_ff;
   logic advance;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   logic acc;
   assign acc = req_tvalid && advance;

   // stage 1: products of inputs
   logic               v1_ff;
   logic signed [31:0] xct1_ff, yst1_ff, yct1_ff, xst1_ff, zsp1_ff, zcp1_ff;
   logic [7:0]         col1_ff;
   logic signed [15:0] px, py, pz;
   assign px = req_tdata[15:0];
   assign py = req_tdata[31:16];
   assign pz = req_tdata[47:32];

   // stage 2: rotation sums and shifts
   logic               v2_ff;
   logic signed [31:0] s3_2_ff, c3_2_ff, xe2_ff, zsp2_ff, zcp2_ff;
   logic [7:0]         col2_ff;
   // stage 3: elevation products
   logic               v3_ff;
   logic signed [47:0] a3_ff, b3_ff;
   logic signed [31:0] xe3_ff;
   logic [7:0]         col3_ff;
   // stage 4: ye, dv
   logic               v4_ff;
   logic signed [35:0] ye4_ff;
   logic signed [39:0] dv4_ff;
   logic signed [31:0] xe4_ff;
   logic [7:0]         col4_ff;

   logic signed [47:0] a3_in, b3_in;
   logic signed [35:0] dvs;

   always_comb begin
      a3_in = (48'(s3_2_ff) - 48'(c3_2_ff)) * 48'(cos_p_ff) + 48'(zsp2_ff);
      b3_in = (48'(s3_2_ff) - 48'(c3_2_ff)) * 48'(sin_p_ff) - 48'(zcp2_ff);
      dvs   = 36'(b3_ff >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= acc; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
      if (advance) begin
         xct1_ff <= -(32'(px) * 32'(cos_t_ff));
         yst1_ff <= 32'(py) * 32'(sin_t_ff);
         yct1_ff <= 32'(py) * 32'(cos_t_ff);
         xst1_ff <= 32'(px) * 32'(sin_t_ff);
         zsp1_ff <= 32'(pz) * 32'(sin_p_ff);
         zcp1_ff <= 32'(pz) * 32'(cos_p_ff);
         col1_ff <= req_tdata[55:48];
         s3_2_ff <= xct1_ff >>> FRAC_BITS;
         c3_2_ff <= yst1_ff >>> FRAC_BITS;
         xe2_ff  <= (yct1_ff - xst1_ff) >>> FRAC_BITS;
         zsp2_ff <= zsp1_ff;
         zcp2_ff <= zcp1_ff;
         col2_ff <= col1_ff;
         a3_ff   <= a3_in;
         b3_ff   <= b3_in;
         xe3_ff  <= xe2_ff;
         col3_ff <= col2_ff;
         ye4_ff  <= 36'(a3_ff >>> FRAC_BITS);
         dv4_ff  <= 40'(dvs) + 40'(vd_ff);
         xe4_ff  <= xe3_ff;
         col4_ff <= col3_ff;
      end
   end

   // divider row
   div_type  d0;
   side_type s0;
   always_comb begin
      d0.rem_num = {sd_ff, {PERSP_BITS{1'b0}}};
      d0.part    = '0;
      d0.quo     = '0;
      d0.den     = dv4_ff[39] ? DEN_W'(-dv4_ff) : DEN_W'(dv4_ff);
      s0.xe      = xe4_ff;
      s0.ye      = 32'(ye4_ff);
      s0.neg     = dv4_ff[39];
      s0.dv_zero = (dv4_ff == '0);
      s0.colour  = col4_ff;
   end

   logic     cv [QUO_W+1];
   div_type  cd [QUO_W+1];
   side_type cs [QUO_W+1];
   assign cv[0] = v4_ff;
   assign cd[0] = d0;
   assign cs[0] = s0;

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      fppp_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (cv[g]),
         .div_in    (cd[g]),
         .side_in   (cs[g]),
         .valid_out (cv[g+1]),
         .div_out   (cd[g+1]),
         .side_out  (cs[g+1])
      );
   end

   // stage A: products with ze
   side_type sf;
   logic signed [QUO_W:0] ze;
   assign sf = cs[QUO_W];
   assign ze = sf.neg ? -$signed({1'b0, cd[QUO_W].quo}) : $signed({1'b0, cd[QUO_W].quo});

   logic               va_ff;
   logic signed [63:0] px_a_ff, py_a_ff;
   logic               zero_a_ff;
   logic [7:0]         col_a_ff;
   // stage B: coordinates
   logic               vb_ff;
   logic [31:0]        cx_b_ff, cy_b_ff;
   logic [7:0]         col_b_ff;

   logic [15:0] off_in;
   logic        hit;
   assign hit    = vb_ff && (cx_b_ff < 32'(SCREEN_WIDTH)) && (cy_b_ff < 32'(SCREEN_HEIGHT));
   assign off_in = 16'(cx_b_ff) + 16'(cy_b_ff[15:0] * 16'(SCREEN_WIDTH));

   logic [15:0] off_ff;
   logic [7:0]  ocol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0; vb_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else if (advance) begin
         va_ff        <= cv[QUO_W];
         vb_ff        <= va_ff && !zero_a_ff;
         out_valid_ff <= hit;
      end
      if (advance) begin
         px_a_ff   <= 64'(sf.xe) * 64'(ze);
         py_a_ff   <= 64'(sf.ye) * 64'(ze);
         zero_a_ff <= sf.dv_zero;
         col_a_ff  <= sf.colour;
         cx_b_ff   <= 32'(64'(SCREEN_WIDTH / 2) + ((px_a_ff * 64'sd5) >>> COL_SHIFT));
         cy_b_ff   <= 32'(64'(SCREEN_HEIGHT / 2) - (py_a_ff >>> ROW_SHIFT));
         col_b_ff  <= col_a_ff;
         off_ff    <= off_in;
         ocol_ff   <= col_b_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {ocol_ff, off_ff};

endmodule

[tb/sv/fixed_point_perspective_plotter_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_perspective_plotter_unit_tb
// Feeds world points through the plotter under several view settings and
// random handshake gaps, predicts the plotted offset and colour of each
// point, and checks every response transaction in order.
// ----------------------------------------------------------------------------
module fixed_point_perspective_plotter_unit_tb;
   import fppp_pkg::*;

   localparam int LATENCY = 34;

   typedef struct {
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] pz;
      logic [7:0]  colour;
      bit          known;
      bit          hit;
      logic [15:0] offset;
   } point_row_t;

   typedef struct {
      logic [15:0] offset;
      logic [7:0]  colour;
   } plot_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   longint view_sin_theta, view_sin_phi, view_cos_theta, view_cos_phi;
   longint view_eye_dist, view_scr_dist;

   plot_t plots_due[$];
   int    errors = 0;
   int    plots_seen = 0;
   int    points_sent = 0;
   int    send_idle_pct = 0;
   int    recv_idle_pct = 0;

   fixed_point_perspective_plotter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("fixed_point_perspective_plotter_unit_tb NOT OK");
      $finish;
   end

   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   // Projects one point; returns 1 with the offset when it lands on screen.
   function automatic bit project_point(logic [15:0] px, logic [15:0] py,
                                        logic [15:0] pz, output logic [15:0] offset);
      longint x, y, z, s3, c3, xe, ye, dv, ze, cx, cy;
      logic [31:0] col, row;
      logic [63:0] full;
      x = longint'($signed(px));
      y = longint'($signed(py));
      z = longint'($signed(pz));
      offset = '0;
      s3 = shr(-x * view_cos_theta, FRAC_BITS);
      c3 = shr(y * view_sin_theta, FRAC_BITS);
      xe = shr(y * view_cos_theta - x * view_sin_theta, FRAC_BITS);
      ye = shr(s3 * view_cos_phi - c3 * view_cos_phi + z * view_sin_phi, FRAC_BITS);
      dv = shr(s3 * view_sin_phi - c3 * view_sin_phi - z * view_cos_phi, FRAC_BITS)
           + view_eye_dist;
      if (dv == 0) return 1'b0;
      ze = (view_scr_dist * (64'sd1 <<< PERSP_BITS)) / dv;
      cx = longint'(SCREEN_WIDTH / 2) + shr(5 * (xe * ze), COL_SHIFT);
      cy = longint'(SCREEN_HEIGHT / 2) - shr(ye * ze, ROW_SHIFT);
      col = cx[31:0];
      row = cy[31:0];
      if (!(col < SCREEN_WIDTH && row < SCREEN_HEIGHT)) return 1'b0;
      full = 64'(col) + 64'(SCREEN_WIDTH) * 64'(row);
      offset = full[15:0];
      return 1'b1;
   endfunction

   task automatic write_reg(logic [3:0] idx, logic [23:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         REG_SIN_THETA: view_sin_theta = longint'($signed(value[13:0]));
         REG_SIN_PHI:   view_sin_phi   = longint'($signed(value[13:0]));
         REG_COS_THETA: view_cos_theta = longint'($signed(value[13:0]));
         REG_COS_PHI:   view_cos_phi   = longint'($signed(value[13:0]));
         REG_VIEW_DIST: view_eye_dist  = longint'($signed(value));
         REG_SCR_DIST:  view_scr_dist  = longint'(value[15:0]);
         default: ;
      endcase
   endtask

   task automatic set_view(int st, int sp, int ct, int cp, int eye, int scr);
      write_reg(REG_SIN_THETA, 24'(st));
      write_reg(REG_SIN_PHI, 24'(sp));
      write_reg(REG_COS_THETA, 24'(ct));
      write_reg(REG_COS_PHI, 24'(cp));
      write_reg(REG_VIEW_DIST, 24'(eye));
      write_reg(REG_SCR_DIST, 24'(scr));
   endtask

   // Waits for the pipeline to drain before touching the registers.
   task automatic drain;
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (plots_due.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   task automatic send_point(point_row_t r);
      logic [15:0] off;
      bit hit;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.colour, r.pz, r.py, r.px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hit = project_point(r.px, r.py, r.pz, off);
      if (r.known && (hit != r.hit || (hit && off != r.offset))) begin
         $display("%0t table row disagrees: expected hit %0b offset %0d, got %0b %0d",
                  $time, r.hit, r.offset, hit, off);
         errors++;
      end
      if (hit) plots_due.push_back('{off, r.colour});
      points_sent++;
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      point_row_t r;
      repeat (count) begin
         r.known  = 1'b0;
         r.colour = 8'($urandom);
         case ($urandom_range(3))
            0: begin
               r.px = 16'($urandom);
               r.py = 16'($urandom);
               r.pz = 16'($urandom);
            end
            default: begin
               r.px = 16'($signed($urandom_range(400)) - 200);
               r.py = 16'($signed($urandom_range(400)) - 200);
               r.pz = 16'($signed($urandom_range(800)) - 400);
            end
         endcase
         send_point(r);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         plots_seen++;
         if (plots_due.size() == 0) begin
            $display("%0t unexpected response: actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            plot_t e;
            e = plots_due.pop_front();
            if (rsp_tdata[15:0] !== e.offset || rsp_tdata[23:16] !== e.colour) begin
               $display("%0t mismatch: expected offset %0d colour %0d, actual %0d %0d",
                        $time, e.offset, e.colour, rsp_tdata[15:0], rsp_tdata[23:16]);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
   end

   point_row_t directed[] = '{
      '{16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b1, 1'b1, 16'd32160},
      '{16'sd0, 16'sd0, 16'sd0, 8'hFF, 1'b1, 1'b1, 16'd32160},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h55, 1'b0, 1'b0, 16'd0},
      '{16'h8000, 16'h8000, 16'h8000, 8'hAA, 1'b0, 1'b0, 16'd0},
      '{16'h8000, 16'h7FFF, 16'h0000, 8'h01, 1'b0, 1'b0, 16'd0},
      '{16'sd0, 16'sd0, 16'sd1024, 8'h12, 1'b0, 1'b0, 16'd0},
      '{16'sd10, 16'sd10, 16'sd0, 8'h34, 1'b0, 1'b0, 16'd0},
      '{16'hFFF6, 16'hFFF6, 16'sd100, 8'h56, 1'b0, 1'b0, 16'd0},
      '{16'sd40, 16'hFFD8, 16'hFF00, 8'h78, 1'b0, 1'b0, 16'd0},
      '{16'sd200, 16'sd0, 16'sd0, 8'h9A, 1'b0, 1'b0, 16'd0}
   };

   initial begin
      // register defaults after reset
      view_sin_theta = 0;
      view_sin_phi   = 0;
      view_cos_theta = 4096;
      view_cos_phi   = 4096;
      view_eye_dist  = 1024;
      view_scr_dist  = 256;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) send_point(directed[i]);
      drain();

      // zero divisor: z = 1024 cancels the eye distance; bogus index ignored
      write_reg(4'd9, 24'hFFFFFF);
      send_point('{16'sd0, 16'sd0, 16'sd1024, 8'h11, 1'b1, 1'b0, 16'd0});
      drain();

      send_idle_pct = 30;
      recv_idle_pct = 53;
      set_view(4096, -4096, -4096, 4096, 8388607, 65535);
      send_random(60);
      drain();
      set_view(-8192, 8191, 0, -4096, -8388608, 0);
      send_random(40);
      drain();
      set_view(2896, 1448, 2896, 3547, 600, 300);
      send_random(100);
      drain();

      send_idle_pct = 53;
      recv_idle_pct = 30;
      set_view(-2048, 3547, 3547, 2048, 2000, 1000);
      send_random(120);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_view(0, 0, 4096, 4096, 1024, 256);
      send_random(100);
      drain();
      set_view(1024, -1024, 3966, 3966, 1, 65535);
      send_random(60);
      drain();

      $display("%0d points sent over seven view settings, %0d plotted", points_sent,
               plots_seen);
      if (errors == 0 && plots_due.size() == 0) begin
         $display("fixed_point_perspective_plotter_unit_tb OK");
      end else begin
         $display("%0d errors, %0d responses missing", errors, plots_due.size());
         $display("fixed_point_perspective_plotter_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
